// ===== design/brs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear RGBA scaler package
// Shared constants, register codes, item types and the frame address map.
// ----------------------------------------------------------------------------

package brs_pkg;

    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int ADDR_W         = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);

    localparam int POS_W      = 12;
    localparam int SRC_W      = 9;
    localparam int DST_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int RATIO_W    = SRC_W + 16;
    localparam int PROD_W     = POS_W + 1 + RATIO_W;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_PRODUCE = 1'b1;

    typedef struct packed {
        logic             action;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [7:0]       in_red;
        logic [7:0]       in_green;
        logic [7:0]       in_blue;
        logic [7:0]       in_alpha;
    } item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } result_t;

    typedef struct packed {
        logic                   is_write;
        logic [3:0][ADDR_W-1:0] addr;
        logic [7:0]             wx;
        logic [7:0]             wy;
        logic [31:0]            data;
    } entry_t;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [POS_W-1:0] y,
                                                     input logic [POS_W-1:0] x);
        return ADDR_W'(y) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(x);
    endfunction

endpackage

`default_nettype wire

// ===== design/brs_ratio_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scale ratio divider
// Restoring divider that forms floor(size * 65536 / dst), one bit per cycle.
// ----------------------------------------------------------------------------

module brs_ratio_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        go,
    input  wire logic [brs_pkg::SRC_W-1:0]   src_size,
    input  wire logic [brs_pkg::DST_W-1:0]   dst_size,
    output logic                             busy,
    output logic [brs_pkg::RATIO_W-1:0]      ratio
);

    localparam int CNT_W = $clog2(brs_pkg::RATIO_W);

    logic                          busy_reg, busy_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [brs_pkg::DST_W-1:0]     rem_reg, rem_next;
    logic [brs_pkg::RATIO_W-1:0]   q_reg, q_next;
    logic [brs_pkg::DST_W-1:0]     den_reg, den_next;
    logic [brs_pkg::DST_W:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        trial     = {rem_reg, q_reg[brs_pkg::RATIO_W-1]};
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = {src_size, 16'd0};
            den_next  = dst_size;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = brs_pkg::DST_W'(trial - {1'b0, den_reg});
                q_next   = {q_reg[brs_pkg::RATIO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[brs_pkg::DST_W-1:0];
                q_next   = {q_reg[brs_pkg::RATIO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(brs_pkg::RATIO_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= brs_pkg::RATIO_W'(65536);
            den_reg  <= brs_pkg::DST_W'(1);
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            den_reg  <= den_next;
        end
    end

    assign busy  = busy_reg;
    assign ratio = q_reg;

endmodule

`default_nettype wire

// ===== design/brs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scaler front end
// Holds the size registers, accepts items and maps destination positions to
// four frame addresses and two weights before they enter the queue.
// ----------------------------------------------------------------------------

module brs_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire brs_pkg::item_t                item,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [brs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [brs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [brs_pkg::QCNT_W-1:0]    q_count,
    output logic                               push,
    output brs_pkg::entry_t                    entry
);

    typedef struct packed {
        logic [brs_pkg::SRC_W-1:0] i0;
        logic [brs_pkg::SRC_W-1:0] i1;
        logic [7:0]                w;
    } axis_t;

    function automatic logic [brs_pkg::SRC_W-1:0] eff_src(input logic [brs_pkg::SRC_W-1:0] v,
                                                          input int maxv);
        if (v == '0)
        begin
            return brs_pkg::SRC_W'(1);
        end
        if (int'(v) > maxv)
        begin
            return brs_pkg::SRC_W'(maxv);
        end
        return v;
    endfunction

    function automatic axis_t axis_map(input logic [brs_pkg::PROD_W-1:0] prod,
                                       input logic [brs_pkg::SRC_W-1:0] eff);
        logic [brs_pkg::PROD_W-2:0]  t;
        logic [brs_pkg::PROD_W-2:0]  u;
        logic [brs_pkg::PROD_W-18:0] idx;
        logic [brs_pkg::SRC_W:0]     nxt;
        logic [brs_pkg::SRC_W-1:0]   last;
        axis_t                       r;
        t    = prod[brs_pkg::PROD_W-1:1];
        u    = '0;
        last = eff - 1'b1;
        r    = '0;
        if (t < (brs_pkg::PROD_W-1)'(32768))
        begin
            idx = '0;
        end
        else
        begin
            u   = t - (brs_pkg::PROD_W-1)'(32768);
            idx = u[brs_pkg::PROD_W-2:16];
            r.w = u[15:8];
        end
        if (idx > (brs_pkg::PROD_W-17)'(last))
        begin
            idx = (brs_pkg::PROD_W-17)'(last);
        end
        r.i0 = idx[brs_pkg::SRC_W-1:0];
        nxt  = {1'b0, r.i0} + 1'b1;
        r.i1 = (nxt < {1'b0, eff}) ? nxt[brs_pkg::SRC_W-1:0] : last;
        return r;
    endfunction

    logic [brs_pkg::SRC_W-1:0] src_w_reg, src_h_reg;
    logic [brs_pkg::DST_W-1:0] dst_w_reg, dst_h_reg;
    logic                      recalc_reg;
    logic [brs_pkg::SRC_W-1:0] eff_sw, eff_sh;
    logic [brs_pkg::DST_W-1:0] eff_dw, eff_dh;
    logic                      div_busy_x, div_busy_y;
    logic [brs_pkg::RATIO_W-1:0] ratio_x, ratio_y;
    logic                      cfg_write;

    logic                      accept;
    logic                      s1_valid_reg;
    brs_pkg::item_t            s1_item_reg;
    logic                      s2_valid_reg;
    brs_pkg::item_t            s2_item_reg;
    logic [brs_pkg::PROD_W-1:0] s2_prod_x_reg, s2_prod_y_reg;
    logic [brs_pkg::QCNT_W:0]  level;
    axis_t                     ax, ay;
    logic                      in_store;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg  <= brs_pkg::SRC_W'(1);
            src_h_reg  <= brs_pkg::SRC_W'(1);
            dst_w_reg  <= brs_pkg::DST_W'(1);
            dst_h_reg  <= brs_pkg::DST_W'(1);
            recalc_reg <= 1'b0;
        end
        else
        begin
            recalc_reg <= cfg_write;
            if (cfg_write)
            begin
                case (cfg_index)
                    brs_pkg::REG_SRC_WIDTH:  src_w_reg <= cfg_data[brs_pkg::SRC_W-1:0];
                    brs_pkg::REG_SRC_HEIGHT: src_h_reg <= cfg_data[brs_pkg::SRC_W-1:0];
                    brs_pkg::REG_DST_WIDTH:  dst_w_reg <= cfg_data;
                    brs_pkg::REG_DST_HEIGHT: dst_h_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign eff_sw = eff_src(src_w_reg, brs_pkg::MAX_SRC_WIDTH);
    assign eff_sh = eff_src(src_h_reg, brs_pkg::MAX_SRC_HEIGHT);
    assign eff_dw = (dst_w_reg == '0) ? brs_pkg::DST_W'(1) : dst_w_reg;
    assign eff_dh = (dst_h_reg == '0) ? brs_pkg::DST_W'(1) : dst_h_reg;

    brs_ratio_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (recalc_reg),
        .src_size (eff_sw),
        .dst_size (eff_dw),
        .busy     (div_busy_x),
        .ratio    (ratio_x)
    );

    brs_ratio_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (recalc_reg),
        .src_size (eff_sh),
        .dst_size (eff_dh),
        .busy     (div_busy_y),
        .ratio    (ratio_y)
    );

    assign level  = {1'b0, q_count} + (brs_pkg::QCNT_W+1)'(s1_valid_reg)
                  + (brs_pkg::QCNT_W+1)'(s2_valid_reg);
    assign busy   = recalc_reg || div_busy_x || div_busy_y
                  || (level >= (brs_pkg::QCNT_W+1)'(brs_pkg::QDEPTH));
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (s1_valid_reg)
        begin
            s2_item_reg   <= s1_item_reg;
            s2_prod_x_reg <= brs_pkg::PROD_W'({s1_item_reg.pos_x, 1'b1})
                           * brs_pkg::PROD_W'(ratio_x);
            s2_prod_y_reg <= brs_pkg::PROD_W'({s1_item_reg.pos_y, 1'b1})
                           * brs_pkg::PROD_W'(ratio_y);
        end
    end

    assign ax = axis_map(s2_prod_x_reg, eff_sw);
    assign ay = axis_map(s2_prod_y_reg, eff_sh);

    assign in_store = (int'(s2_item_reg.pos_x) < brs_pkg::MAX_SRC_WIDTH)
                   && (int'(s2_item_reg.pos_y) < brs_pkg::MAX_SRC_HEIGHT);

    always_comb
    begin
        entry      = '0;
        entry.data = {s2_item_reg.in_alpha, s2_item_reg.in_blue,
                      s2_item_reg.in_green, s2_item_reg.in_red};
        if (s2_item_reg.action == brs_pkg::ACT_WRITE)
        begin
            entry.is_write = 1'b1;
            entry.addr[0]  = brs_pkg::store_addr(s2_item_reg.pos_y, s2_item_reg.pos_x);
            push           = s2_valid_reg && in_store;
        end
        else
        begin
            entry.is_write = 1'b0;
            entry.addr[0]  = brs_pkg::store_addr(brs_pkg::POS_W'(ay.i0),
                                                 brs_pkg::POS_W'(ax.i0));
            entry.addr[1]  = brs_pkg::store_addr(brs_pkg::POS_W'(ay.i0),
                                                 brs_pkg::POS_W'(ax.i1));
            entry.addr[2]  = brs_pkg::store_addr(brs_pkg::POS_W'(ay.i1),
                                                 brs_pkg::POS_W'(ax.i0));
            entry.addr[3]  = brs_pkg::store_addr(brs_pkg::POS_W'(ay.i1),
                                                 brs_pkg::POS_W'(ax.i1));
            entry.wx       = ax.w;
            entry.wy       = ay.w;
            push           = s2_valid_reg;
        end
    end

endmodule

`default_nettype wire

// ===== design/brs_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scaler command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------

module brs_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire brs_pkg::entry_t            entry_in,
    input  wire logic                       pop,
    output brs_pkg::entry_t                 entry_out,
    output logic                            not_empty,
    output logic [brs_pkg::QCNT_W-1:0]      count
);

    brs_pkg::entry_t                slot_reg [brs_pkg::QDEPTH];
    logic [brs_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [brs_pkg::QCNT_W-1:0]     count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

    assign entry_out = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg != brs_pkg::QCNT_W'(brs_pkg::QDEPTH)))
        else $error("queue written while full");

endmodule

`default_nettype wire

// ===== design/brs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scaler back end
// Owns the frame memory, stores pixels, fetches four neighbors per output
// pixel through its single port and blends them in two registered stages.
// ----------------------------------------------------------------------------

module brs_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire brs_pkg::entry_t  entry,
    output logic                  pop,
    output logic                  done,
    output brs_pkg::result_t      result
);

    localparam int DEPTH = brs_pkg::MAX_SRC_WIDTH * brs_pkg::MAX_SRC_HEIGHT;

    logic [31:0]      mem [DEPTH];
    logic [31:0]      mem_q;

    brs_pkg::entry_t  cur_reg;
    logic             cur_valid_reg;
    logic [1:0]       phase_reg;
    logic             finish;
    logic             mem_we;

    logic             tag_valid_reg;
    logic [1:0]       tag_phase_reg;
    logic [7:0]       tag_wx_reg, tag_wy_reg;
    logic [31:0]      pix_reg [3];

    logic             h_valid_reg;
    logic [7:0]       h_wy_reg;
    logic [15:0]      h_top_reg [4];
    logic [15:0]      h_bot_reg [4];
    logic             h_load;

    logic [8:0]       cwx, cwy, hwy;
    logic [15:0]      top_c [4];
    logic [15:0]      bot_c [4];
    logic [24:0]      v_c [4];
    logic [7:0]       ch_c [4];

    logic             done_reg;
    brs_pkg::result_t result_reg;

    assign finish = cur_valid_reg && (cur_reg.is_write || phase_reg == 2'd3);
    assign pop    = q_valid && (!cur_valid_reg || finish);
    assign mem_we = cur_valid_reg && cur_reg.is_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= '0;
            tag_valid_reg <= 1'b0;
            h_valid_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                phase_reg     <= '0;
            end
            else
            begin
                if (finish)
                begin
                    cur_valid_reg <= 1'b0;
                end
                if (cur_valid_reg && !cur_reg.is_write)
                begin
                    phase_reg <= phase_reg + 1'b1;
                end
            end
            tag_valid_reg <= cur_valid_reg && !cur_reg.is_write;
            h_valid_reg   <= h_load;
            done_reg      <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= entry;
        end
        tag_phase_reg <= phase_reg;
        tag_wx_reg    <= cur_reg.wx;
        tag_wy_reg    <= cur_reg.wy;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cur_reg.addr[0]] <= cur_reg.data;
        end
        else
        begin
            mem_q <= mem[cur_reg.addr[phase_reg]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_valid_reg && tag_phase_reg == 2'd0)
        begin
            pix_reg[0] <= mem_q;
        end
        if (tag_valid_reg && tag_phase_reg == 2'd1)
        begin
            pix_reg[1] <= mem_q;
        end
        if (tag_valid_reg && tag_phase_reg == 2'd2)
        begin
            pix_reg[2] <= mem_q;
        end
    end

    assign h_load = tag_valid_reg && (tag_phase_reg == 2'd3);
    assign cwx    = 9'd256 - {1'b0, tag_wx_reg};
    assign cwy    = 9'd256 - {1'b0, h_wy_reg};
    assign hwy    = {1'b0, h_wy_reg};

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            top_c[c] = 16'(pix_reg[0][8*c +: 8]) * 16'(cwx)
                     + 16'(pix_reg[1][8*c +: 8]) * 16'(tag_wx_reg);
            bot_c[c] = 16'(pix_reg[2][8*c +: 8]) * 16'(cwx)
                     + 16'(mem_q[8*c +: 8]) * 16'(tag_wx_reg);
            v_c[c]   = 25'(h_top_reg[c]) * 25'(cwy) + 25'(h_bot_reg[c]) * 25'(hwy);
            ch_c[c]  = (v_c[c][24:16] > 9'd255) ? 8'd255 : v_c[c][23:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_load)
        begin
            h_wy_reg <= tag_wy_reg;
            for (int c = 0; c < 4; c++)
            begin
                h_top_reg[c] <= top_c[c];
                h_bot_reg[c] <= bot_c[c];
            end
        end
        if (h_valid_reg)
        begin
            result_reg.out_red   <= ch_c[0];
            result_reg.out_green <= ch_c[1];
            result_reg.out_blue  <= ch_c[2];
            result_reg.out_alpha <= ch_c[3];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_phase_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != 2'd0) |-> (cur_valid_reg && !cur_reg.is_write))
        else $error("fetch phase advanced without a produce item");

    a_last_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (tag_valid_reg && tag_phase_reg == 2'd3) |=> h_valid_reg)
        else $error("fourth neighbor did not enter the blend stage");

    a_blend_done: assert property (@(posedge clk) disable iff (!rst_n)
        h_valid_reg |=> done_reg)
        else $error("blend stage did not deliver a result");

endmodule

`default_nettype wire

// ===== design/bilinear_rgba_image_scaler_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear RGBA image scaler core
// Stores a source image and returns bilinearly resized destination pixels.
// ----------------------------------------------------------------------------
// Items enter on start while busy is low. A write item stores one RGBA pixel
// at (pos_x, pos_y) and produces no result. A produce item returns one
// destination pixel on result, marked by done for exactly one cycle; the
// receiver takes every result and cannot stall the block.
// The four size registers are to be written through the cfg channel only
// while the block is idle; the block itself does not enforce this. After each
// write busy stays high while the scale ratios are recomputed by two
// bit-serial dividers. A produce item reads the single-port frame memory once
// per neighbor, and the back end takes its next item only when the fourth of
// these reads is issued. Items are served strictly in order.
// Reset clears the size registers to one and empties the pipeline; the frame
// memory content is not cleared and pixels must be written before they are
// read.
// ----------------------------------------------------------------------------

module bilinear_rgba_image_scaler_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire brs_pkg::item_t                 item,
    output logic                                done,
    output brs_pkg::result_t                    result,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [brs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [brs_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                          push, pop, q_valid;
    brs_pkg::entry_t               push_entry, head_entry;
    logic [brs_pkg::QCNT_W-1:0]    q_count;

    brs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_count   (q_count),
        .push      (push),
        .entry     (push_entry)
    );

    brs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (push_entry),
        .pop       (pop),
        .entry_out (head_entry),
        .not_empty (q_valid),
        .count     (q_count)
    );

    brs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .entry   (head_entry),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire
